>>> sv/r2fft_pkg.sv
// Shared types and constants for the radix-2 FFT core.
package r2fft_pkg;
  localparam int DATA_W = 24;
  localparam int SAMPLE_W = 16;
  localparam int ROM_FRAC = 23;
  localparam int ROM_LOG2 = 6;
  localparam logic signed [DATA_W-1:0] SAT_MAX = 24'sh7FFFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = -24'sh800000;

  localparam logic [0:0] REG_DIRECTION = 1'b0;
  localparam logic [0:0] REG_SIZE = 1'b1;

  typedef logic signed [DATA_W-1:0] data_t;

  // cos(2*pi*k/64), k = 0..16, scaled by 2^23
  function automatic logic [23:0] cos_rom(input logic [4:0] k);
    logic [23:0] v;
    case (k)
      5'd0: v = 24'd8388608;
      5'd1: v = 24'd8348215;
      5'd2: v = 24'd8227423;
      5'd3: v = 24'd8027397;
      5'd4: v = 24'd7750063;
      5'd5: v = 24'd7398092;
      5'd6: v = 24'd6974873;
      5'd7: v = 24'd6484482;
      5'd8: v = 24'd5931642;
      5'd9: v = 24'd5321677;
      5'd10: v = 24'd4660461;
      5'd11: v = 24'd3954362;
      5'd12: v = 24'd3210181;
      5'd13: v = 24'd2435084;
      5'd14: v = 24'd1636536;
      5'd15: v = 24'd822227;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

  function automatic data_t sat24(input logic signed [DATA_W+1:0] x);
    data_t r;
    if (x > 26'(SAT_MAX)) r = SAT_MAX;
    else if (x < 26'(SAT_MIN)) r = SAT_MIN;
    else r = x[DATA_W-1:0];
    return r;
  endfunction
endpackage

>>> sv/radix2_fft_inplace_core.sv
// Top level: sample store, butterfly sequencer and bin output.
//  channel | ports                                  | handshake
//  in      | in_sample_real, in_sample_imag         | start & !busy
//  out     | out_bin_real/imag/index, frame_last    | out_valid, one cycle
//  cfg     | cfg_we, cfg_index, cfg_data            | cfg_we
// One sample is loaded per cycle while the core is not busy. On the last sample
// the core is busy for N reorder steps (read, then swap), N/2*log2N butterflies
// (read, multiply, register products, write back; one store port pair), optional
// N scaling steps (read, then write), then one priming read and N output bins.
// Reset clears counters and control; the store is not cleared.
module radix2_fft_inplace_core #(
  parameter int MAX_LOG2_POINTS = 6,
  parameter int TWIDDLE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic signed [15:0] in_sample_real,
  input  logic signed [15:0] in_sample_imag,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [2:0] cfg_data,
  output logic out_valid,
  output logic signed [23:0] out_bin_real,
  output logic signed [23:0] out_bin_imag,
  output logic [5:0] out_bin_index,
  output logic out_frame_last
);
  import r2fft_pkg::*;
  localparam int AW = MAX_LOG2_POINTS;
  localparam int DEPTH = 1 << AW;

  localparam logic [2:0] S_LOAD = 3'd0, S_REV = 3'd1, S_BF = 3'd2,
                         S_SCL = 3'd3, S_OUT = 3'd4;

  data_t mem_re [DEPTH];
  data_t mem_im [DEPTH];

  logic dir_r;
  logic [2:0] size_r;
  logic [2:0] state_r, state_nxt;
  logic [AW:0] cnt_r, cnt_nxt;       // load count / item counter
  logic [1:0] ph_r, ph_nxt;           // sub-step phase
  logic [2:0] stg_r, stg_nxt;         // butterfly stage 1..L
  logic [2:0] l_r, l_nxt;             // latched effective log2
  logic [AW-1:0] ia_r, ib_r;          // latched addresses
  data_t ra_re_r, ra_im_r, rb_re_r, rb_im_r;
  data_t rd_re_r, rd_im_r;

  logic [2:0] l_eff;
  always_comb begin
    l_eff = size_r;
    if (l_eff < 3'd1) l_eff = 3'd1;
    if (32'(l_eff) > MAX_LOG2_POINTS) l_eff = 3'(MAX_LOG2_POINTS);
  end

  logic [AW:0] n_pts;
  assign n_pts = (AW+1)'(1) << l_r;

  // bit reverse of cnt over l_r bits
  logic [AW-1:0] rev_idx;
  always_comb begin
    rev_idx = '0;
    for (int i = 0; i < AW; i++)
      if (i < int'(l_r)) rev_idx[int'(l_r) - 1 - i] = cnt_r[i];
  end

  // butterfly addressing from butterfly counter cnt_r (0..N/2-1)
  logic [AW-1:0] half, j_idx, k_idx;
  logic [AW:0] grp;
  logic [4:0] tw_angle;
  always_comb begin
    half = AW'(1) << (stg_r - 3'd1);
    j_idx = cnt_r[AW-1:0] & (half - AW'(1));
    grp = cnt_r >> (stg_r - 3'd1);
    k_idx = AW'(grp << stg_r) | j_idx;
    tw_angle = 5'(32'(j_idx) << (ROM_LOG2 - int'(stg_r)));
  end

  logic signed [TWIDDLE_BITS-1:0] w_re, w_im;
  data_t x_re, x_im, y_re, y_im;

  r2fft_twiddle #(.TWIDDLE_BITS(TWIDDLE_BITS)) u_tw (
    .angle(tw_angle), .fwd(dir_r), .w_re(w_re), .w_im(w_im)
  );
  r2fft_bfly #(.TWIDDLE_BITS(TWIDDLE_BITS)) u_bf (
    .clk(clk), .a_re(ra_re_r), .a_im(ra_im_r), .b_re(rb_re_r), .b_im(rb_im_r),
    .w_re(w_re), .w_im(w_im), .x_re(x_re), .x_im(x_im), .y_re(y_re), .y_im(y_im)
  );

  // scaled value of the read word
  logic signed [DATA_W+1:0] sc_re, sc_im;
  always_comb begin
    sc_re = (26'(rd_re_r) + (26'sd1 <<< (l_r - 3'd1))) >>> l_r;
    sc_im = (26'(rd_im_r) + (26'sd1 <<< (l_r - 3'd1))) >>> l_r;
  end

  logic accept;
  assign accept = start && !busy;
  assign busy = (state_r != S_LOAD);

  // memory port control
  logic we_a, we_b, rd_a;
  logic [AW-1:0] wa_addr, wb_addr, ra_addr, rb_addr;
  data_t wa_re, wa_im, wb_re, wb_im;

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; ph_nxt = ph_r;
    stg_nxt = stg_r; l_nxt = l_r;
    we_a = 1'b0; we_b = 1'b0; rd_a = 1'b0;
    wa_addr = cnt_r[AW-1:0]; wb_addr = ib_r;
    ra_addr = cnt_r[AW-1:0]; rb_addr = rev_idx;
    wa_re = DATA_W'(in_sample_real); wa_im = DATA_W'(in_sample_imag);
    wb_re = ra_re_r; wb_im = ra_im_r;
    case (state_r)
      S_LOAD: begin
        if (accept) begin
          we_a = 1'b1;
          wa_re = DATA_W'(in_sample_real);
          wa_im = DATA_W'(in_sample_imag);
          if (cnt_r + 1'b1 >= ((AW+1)'(1) << l_eff)) begin
            cnt_nxt = '0; ph_nxt = '0; l_nxt = l_eff; state_nxt = S_REV;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_REV: begin
        // phase 0 read both, phase 1 swap
        if (ph_r == 2'd0) begin
          rd_a = 1'b1; ph_nxt = 2'd1;
        end else begin
          if (cnt_r[AW-1:0] < rev_idx) begin
            we_a = 1'b1; wa_addr = cnt_r[AW-1:0]; wa_re = rb_re_r; wa_im = rb_im_r;
            we_b = 1'b1; wb_addr = rev_idx; wb_re = ra_re_r; wb_im = ra_im_r;
          end
          ph_nxt = 2'd0;
          if (cnt_r + 1'b1 == n_pts) begin
            cnt_nxt = '0; stg_nxt = 3'd1; state_nxt = S_BF;
          end else cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_BF: begin
        ra_addr = k_idx; rb_addr = k_idx | half;
        case (ph_r)
          2'd0: begin rd_a = 1'b1; ph_nxt = 2'd1; end
          2'd1: ph_nxt = 2'd2;     // operands to multipliers
          2'd2: ph_nxt = 2'd3;     // products registered
          default: begin
            we_a = 1'b1; wa_addr = ia_r; wa_re = x_re; wa_im = x_im;
            we_b = 1'b1; wb_addr = ib_r; wb_re = y_re; wb_im = y_im;
            ph_nxt = 2'd0;
            if (cnt_r + 1'b1 == (n_pts >> 1)) begin
              cnt_nxt = '0;
              if (stg_r == l_r) state_nxt = dir_r ? S_SCL : S_OUT;
              else stg_nxt = stg_r + 3'd1;
            end else cnt_nxt = cnt_r + 1'b1;
          end
        endcase
      end
      S_SCL: begin
        if (ph_r == 2'd0) begin
          rd_a = 1'b1; ph_nxt = 2'd1;
        end else begin
          we_a = 1'b1; wa_addr = ia_r; wa_re = sat24(sc_re); wa_im = sat24(sc_im);
          ph_nxt = 2'd0;
          if (cnt_r + 1'b1 == n_pts) begin
            cnt_nxt = '0; state_nxt = S_OUT;
          end else cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_OUT: begin
        // ph 0: prime read of bin 0, then one bin per cycle
        rd_a = 1'b1;
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1; cnt_nxt = cnt_r + 1'b1;
          ra_addr = '0;
        end else if (cnt_r == n_pts) begin
          cnt_nxt = '0; ph_nxt = '0; state_nxt = S_LOAD;
        end else cnt_nxt = cnt_r + 1'b1;
      end
      default: state_nxt = S_LOAD;
    endcase
    if (cfg_we && cfg_index == REG_SIZE && state_r == S_LOAD) cnt_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_re[wa_addr] <= wa_re;
      mem_im[wa_addr] <= wa_im;
    end
    if (we_b) begin
      mem_re[wb_addr] <= wb_re;
      mem_im[wb_addr] <= wb_im;
    end
    if (rd_a) begin
      ra_re_r <= mem_re[ra_addr];
      ra_im_r <= mem_im[ra_addr];
      rb_re_r <= mem_re[rb_addr];
      rb_im_r <= mem_im[rb_addr];
      rd_re_r <= mem_re[ra_addr];
      rd_im_r <= mem_im[ra_addr];
      ia_r <= ra_addr;
      ib_r <= rb_addr;
    end
  end

  logic ov_r;
  logic [AW:0] oi_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; cnt_r <= '0; ph_r <= '0; stg_r <= 3'd1; l_r <= 3'd1;
      dir_r <= 1'b1; size_r <= 3'd6; ov_r <= 1'b0; oi_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; ph_r <= ph_nxt;
      stg_r <= stg_nxt; l_r <= l_nxt;
      if (cfg_we && cfg_index == REG_DIRECTION) dir_r <= cfg_data[0];
      if (cfg_we && cfg_index == REG_SIZE) size_r <= cfg_data;
      ov_r <= (state_r == S_OUT) && (cnt_r != n_pts);
      oi_r <= cnt_r;
    end
  end

  // output read is registered; its address was cnt_r in the cycle before
  assign out_valid = ov_r;
  assign out_bin_real = ra_re_r;
  assign out_bin_imag = ra_im_r;
  assign out_bin_index = 6'(oi_r[AW-1:0]);
  assign out_frame_last = ov_r && (oi_r == n_pts - 1'b1);
endmodule

>>> sv/r2fft_twiddle.sv
// Twiddle factor lookup: quarter-wave ROM, rounded and clipped.
module r2fft_twiddle #(
  parameter int TWIDDLE_BITS = 16
) (
  input  logic [4:0] angle,
  input  logic fwd,
  output logic signed [TWIDDLE_BITS-1:0] w_re,
  output logic signed [TWIDDLE_BITS-1:0] w_im
);
  import r2fft_pkg::*;
  localparam int DROP = ROM_FRAC - (TWIDDLE_BITS - 1);
  localparam logic [24:0] LIMIT = 25'((1 << (TWIDDLE_BITS - 1)) - 1);

  function automatic logic [24:0] cut(input logic [23:0] m);
    logic [24:0] v;
    v = {1'b0, m};
    if (DROP > 0) v = (v + (25'd1 << (DROP - 1))) >> DROP;
    if (v > LIMIT) v = LIMIT;
    return v;
  endfunction

  logic [23:0] c_mag, s_mag;
  logic c_neg;
  logic [24:0] c_cut, s_cut;

  always_comb begin
    if (angle <= 5'd16) begin
      c_mag = cos_rom(angle);
      s_mag = cos_rom(5'd16 - angle);
      c_neg = 1'b0;
    end else begin
      c_mag = cos_rom(5'd0 - angle);
      s_mag = cos_rom(angle - 5'd16);
      c_neg = 1'b1;
    end
    c_cut = cut(c_mag);
    s_cut = cut(s_mag);
    w_re = c_neg ? -TWIDDLE_BITS'(c_cut) : TWIDDLE_BITS'(c_cut);
    w_im = fwd ? -TWIDDLE_BITS'(s_cut) : TWIDDLE_BITS'(s_cut);
  end
endmodule

>>> sv/r2fft_bfly.sv
// Pipelined radix-2 butterfly: register after the products, then add and saturate.
module r2fft_bfly #(
  parameter int TWIDDLE_BITS = 16
) (
  input  logic clk,
  input  r2fft_pkg::data_t a_re, a_im, b_re, b_im,
  input  logic signed [TWIDDLE_BITS-1:0] w_re, w_im,
  output r2fft_pkg::data_t x_re, x_im, y_re, y_im
);
  import r2fft_pkg::*;
  localparam int PW = DATA_W + TWIDDLE_BITS;
  localparam int FR = TWIDDLE_BITS - 1;

  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  data_t a_re_r, a_im_r;
  logic signed [PW:0] t_re_full, t_im_full;
  logic signed [DATA_W+1:0] t_re, t_im;

  always_ff @(posedge clk) begin
    p_rr_r <= b_re * w_re;
    p_ii_r <= b_im * w_im;
    p_ri_r <= b_re * w_im;
    p_ir_r <= b_im * w_re;
    a_re_r <= a_re;
    a_im_r <= a_im;
  end

  always_comb begin
    t_re_full = ((PW+1)'(p_rr_r) - (PW+1)'(p_ii_r) + ((PW+1)'(1) <<< (FR - 1))) >>> FR;
    t_im_full = ((PW+1)'(p_ri_r) + (PW+1)'(p_ir_r) + ((PW+1)'(1) <<< (FR - 1))) >>> FR;
    t_re = t_re_full[DATA_W+1:0];
    t_im = t_im_full[DATA_W+1:0];
    x_re = sat24(26'(a_re_r) + t_re);
    x_im = sat24(26'(a_im_r) + t_im);
    y_re = sat24(26'(a_re_r) - t_re);
    y_im = sat24(26'(a_im_r) - t_im);
  end
endmodule

>>> sv/r2fft_checker.sv
// Port-level checks for the FFT core, bound to the top level.
module r2fft_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic [5:0] out_bin_index,
  input logic out_frame_last
);
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_frame_last |-> out_valid) else $error("frame_last without strobe");
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("bin while idle");
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_last |=> !out_valid || out_bin_index == $past(out_bin_index) + 6'd1)
    else $error("bin index skipped");
  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_bin_index == 6'd0) else $error("frame not from bin 0");
endmodule

bind radix2_fft_inplace_core r2fft_checker u_chk (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_bin_index(out_bin_index), .out_frame_last(out_frame_last)
);

>>> dv/tb.sv
// Testbench for radix2_fft_inplace_core: bit-exact FFT bin prediction and checking.
`timescale 1ns / 1ps

module tb;
  import r2fft_pkg::*;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
  } sample_t;

  typedef struct {
    data_t re;
    data_t im;
    logic [5:0] idx;
    logic last;
  } bin_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int FRAC = 15;
  localparam int COS_TAB [17] = '{8388608, 8348215, 8227423, 8027397, 7750063, 7398092,
    6974873, 6484482, 5931642, 5321677, 4660461, 3954362, 3210181, 2435084, 1636536,
    822227, 0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_sample_real = '0;
  logic signed [15:0] in_sample_imag = '0;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_DIRECTION;
  logic [2:0] cfg_data = '0;
  logic out_valid;
  logic signed [23:0] out_bin_real;
  logic signed [23:0] out_bin_imag;
  logic [5:0] out_bin_index;
  logic out_frame_last;

  radix2_fft_inplace_core uut (.*);

  always #10 clk = ~clk;

  sample_t pending_samples[$];
  bin_t expected_bins[$];
  int idle_pct = 0;
  int stall_cycles = 0;
  bit failed = 1'b0;

  // shadow of the core's registers and sample store
  bit fwd_mode = 1'b1;
  bit [2:0] size_reg = 3'd6;
  int unsigned loaded = 0;
  longint fft_re [64];
  longint fft_im [64];

  function automatic longint sat24_model(longint x);
    if (x > 8388607) return 8388607;
    if (x < -8388608) return -8388608;
    return x;
  endfunction

  // round to nearest, ties up
  function automatic longint round_shr(longint x, int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint twiddle_part(int mag, bit neg);
    longint m;
    m = (mag + 128) >> 8;
    if (m > 32767) m = 32767;
    return neg ? -m : m;
  endfunction

  task automatic run_fft(int l);
    int n, r, half, e;
    longint wr, wi, t, ar, ai, br, bi, tr, ti;
    n = 1 << l;
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int b = 0; b < l; b++) r = (r << 1) | ((i >> b) & 1);
      if (i < r) begin
        t = fft_re[i]; fft_re[i] = fft_re[r]; fft_re[r] = t;
        t = fft_im[i]; fft_im[i] = fft_im[r]; fft_im[r] = t;
      end
    end
    for (int s = 1; s <= l; s++) begin
      half = 1 << (s - 1);
      for (int j = 0; j < half; j++) begin
        e = (j << (6 - s)) & 31;
        if (e <= 16) begin
          wr = twiddle_part(COS_TAB[e], 1'b0);
          wi = twiddle_part(COS_TAB[16 - e], fwd_mode);
        end else begin
          wr = twiddle_part(COS_TAB[32 - e], 1'b1);
          wi = twiddle_part(COS_TAB[e - 16], fwd_mode);
        end
        for (int k = j; k < n; k += 2 * half) begin
          br = fft_re[k + half]; bi = fft_im[k + half];
          ar = fft_re[k]; ai = fft_im[k];
          tr = round_shr(br * wr - bi * wi, FRAC);
          ti = round_shr(br * wi + bi * wr, FRAC);
          fft_re[k] = sat24_model(ar + tr);
          fft_im[k] = sat24_model(ai + ti);
          fft_re[k + half] = sat24_model(ar - tr);
          fft_im[k + half] = sat24_model(ai - ti);
        end
      end
    end
    if (fwd_mode) begin
      for (int i = 0; i < n; i++) begin
        fft_re[i] = sat24_model(round_shr(fft_re[i], l));
        fft_im[i] = sat24_model(round_shr(fft_im[i], l));
      end
    end
  endtask

  task automatic load_sample(logic signed [15:0] re, logic signed [15:0] im);
    int l, n;
    bin_t b;
    l = (size_reg == 0) ? 1 : (size_reg > 6) ? 6 : size_reg;
    n = 1 << l;
    fft_re[loaded & 63] = re;
    fft_im[loaded & 63] = im;
    loaded = (loaded + 1) & 127;
    if (loaded >= n) begin
      loaded = 0;
      run_fft(l);
      for (int k = 0; k < n; k++) begin
        b.re = data_t'(fft_re[k]);
        b.im = data_t'(fft_im[k]);
        b.idx = 6'(k);
        b.last = (k == n - 1);
        expected_bins.push_back(b);
      end
    end
  endtask

  // driver: holds a request until the core takes it
  always @(posedge clk) begin
    sample_t s;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) load_sample(in_sample_real, in_sample_imag);
      if (!start || !busy) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
          s = pending_samples.pop_front();
          start <= 1'b1;
          in_sample_real <= s.re;
          in_sample_imag <= s.im;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    bin_t b;
    if (rst_n && out_valid) begin
      if (expected_bins.size() == 0) begin
        $error("unexpected bin index %0d", out_bin_index);
        failed = 1'b1;
      end else begin
        b = expected_bins.pop_front();
        if (out_bin_real !== b.re) begin
          $error("bin_real: expected %0d, got %0d", b.re, out_bin_real);
          failed = 1'b1;
        end
        if (out_bin_imag !== b.im) begin
          $error("bin_imag: expected %0d, got %0d", b.im, out_bin_imag);
          failed = 1'b1;
        end
        if (out_bin_index !== b.idx) begin
          $error("bin_index: expected %0d, got %0d", b.idx, out_bin_index);
          failed = 1'b1;
        end
        if (out_frame_last !== b.last) begin
          $error("frame_last: expected %0d, got %0d", b.last, out_frame_last);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles with no accepted request, bin or register write
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [2:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DIRECTION) begin
      fwd_mode = d[0];
    end else begin
      size_reg = d;
      loaded = 0;
    end
  endtask

  // checked away from the driving edge so that queue and strobe are settled
  task automatic drain;
    do @(negedge clk);
    while (pending_samples.size() != 0 || start || busy || expected_bins.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic push(int re, int im);
    sample_t s;
    s.re = 16'(re);
    s.im = 16'(im);
    pending_samples.push_back(s);
  endtask

  function automatic int rand_value();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 32767 : -32768;
      1: return int'($urandom_range(64)) - 32;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  initial begin
    int sizes [8] = '{6, 1, 2, 3, 7, 4, 5, 0};
    int idle_set [4] = '{0, 77, 0, 13};
    int count;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // size 1 forward, both extremes
    write_reg(REG_SIZE, 3'd1);
    push(32767, -32768); push(-32768, 32767);
    push(-32768, -32768); push(-32768, -32768);
    drain();
    // size 0 behaves as 1, inverse
    write_reg(REG_SIZE, 3'd0);
    write_reg(REG_DIRECTION, 3'd0);
    drain();
    push(32767, 32767); push(32767, 32767);
    drain();
    // partial frame dropped by a size write
    write_reg(REG_SIZE, 3'd3);
    push(1000, -1000); push(-5, 7); push(32767, 0);
    drain();
    write_reg(REG_SIZE, 3'd2);
    push(32767, 0); push(0, 32767); push(-32768, 0); push(0, -32768);
    drain();
    // direction change mid-frame applies to the frame in progress
    push(12345, -2345);
    drain();
    write_reg(REG_DIRECTION, 3'd1);
    push(-1, 1); push(32767, -32768); push(4, 0);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_reg(REG_DIRECTION, {2'($urandom_range(3)), 1'(p % 2 == 0)});
      write_reg(REG_SIZE, 3'(sizes[p]));
      idle_pct = idle_set[p % 4];
      count = (sizes[p] >= 6 || sizes[p] == 7) ? 64 : 32;
      for (int i = 0; i < count; i++) push(rand_value(), rand_value());
      drain();
    end

    if (!failed && expected_bins.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
